// File: rtl/core/msbp_pkg.sv
package msbp_pkg;

    // default sizes; table sizes are powers of two
    localparam int DEF_COUNTER_ENTRIES = 4096;
    localparam int DEF_HISTORY_BITS    = 12;
    localparam int DEF_PERCEPTRON_ROWS = 1024;
    localparam int DEF_WEIGHT_BITS     = 8;

    // field and register widths
    localparam int PC_W        = 32;
    localparam int OFFSET_W    = 13;
    localparam int STRATEGY_W  = 3;
    localparam int THRESHOLD_W = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 11;

    // register reset values
    localparam logic [STRATEGY_W-1:0]  STRATEGY_RESET  = 3'd3;
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 11'd37;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_STRATEGY  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 1'b1;

    // strategy codes
    localparam logic [STRATEGY_W-1:0] STRAT_NEVER      = 3'd0;
    localparam logic [STRATEGY_W-1:0] STRAT_ALWAYS     = 3'd1;
    localparam logic [STRATEGY_W-1:0] STRAT_BACKWARD   = 3'd2;
    localparam logic [STRATEGY_W-1:0] STRAT_COUNTER    = 3'd3;
    localparam logic [STRATEGY_W-1:0] STRAT_PERCEPTRON = 3'd4;

    // opcodes
    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    // 2-bit counter states
    localparam logic [1:0] CNT_STRONG_NT  = 2'd0;
    localparam logic [1:0] CNT_WEAK_TAKEN = 2'd2;
    localparam logic [1:0] CNT_STRONG_T   = 2'd3;

    // history entries, two's complement +1 / -1 / 0
    localparam logic [1:0] HIST_NONE  = 2'b00;
    localparam logic [1:0] HIST_PLUS  = 2'b01;
    localparam logic [1:0] HIST_MINUS = 2'b11;

    // confidence classes
    localparam logic [1:0] CONF_NONE  = 2'd0;
    localparam logic [1:0] CONF_TAKEN = 2'd1;
    localparam logic [1:0] CONF_NOT   = 2'd2;

    // control of the shared lane unit
    typedef struct packed {
        logic       train;
        logic       dir_taken;
        logic [1:0] hist;
    } t_lane_ctl;

endpackage

// File: rtl/core/multi_strategy_branch_predictor.sv
// channel   direction  handshake                  payload
// item in   input      i_valid / o_ready          i_opcode, i_pc, i_offset, i_taken
// result    output     o_valid / i_ready          o_predict_taken
// config    input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// after reset a clearing pass over max(COUNTER_ENTRIES, PERCEPTRON_ROWS) addresses (4096 by
// default) fills the counter table and zeroes the weight rows; only config writes are taken.
// simple strategies and counter updates are done in the evaluate step; a perceptron predict,
// or a training update that is not skipped, then walks the row in the shared lane adder, one
// weight per step, and ends in a final step. a result waits in the output register while the
// next item is accepted; emit stalls until that register frees.
module multi_strategy_branch_predictor #(
    parameter int COUNTER_ENTRIES = msbp_pkg::DEF_COUNTER_ENTRIES,
    parameter int HISTORY_BITS    = msbp_pkg::DEF_HISTORY_BITS,
    parameter int PERCEPTRON_ROWS = msbp_pkg::DEF_PERCEPTRON_ROWS,
    parameter int WEIGHT_BITS     = msbp_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_opcode,
    input  logic [msbp_pkg::PC_W-1:0]           i_pc,
    input  logic signed [msbp_pkg::OFFSET_W-1:0] i_offset,
    input  logic                                i_taken,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_predict_taken,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [msbp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [msbp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CIDX_W    = $clog2(COUNTER_ENTRIES);
    localparam int RIDX_W    = $clog2(PERCEPTRON_ROWS);
    localparam int ROW_LEN   = HISTORY_BITS + 1;
    localparam int ROW_W     = ROW_LEN * WEIGHT_BITS;
    localparam int LANE_W    = $clog2(ROW_LEN);
    localparam int HIDX_W    = (HISTORY_BITS > 1) ? $clog2(HISTORY_BITS) : 1;
    localparam int SUM_W     = WEIGHT_BITS + $clog2(ROW_LEN) + 1;
    localparam int THR_W     = msbp_pkg::THRESHOLD_W;
    localparam int CMP_W     = ((SUM_W > THR_W + 1) ? SUM_W : THR_W + 1) + 1;
    localparam int CLR_DEPTH = (COUNTER_ENTRIES > PERCEPTRON_ROWS) ?
                               COUNTER_ENTRIES : PERCEPTRON_ROWS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam logic [CLR_W-1:0]  CLR_LAST  = CLR_W'(CLR_DEPTH - 1);
    localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(HISTORY_BITS);
    localparam logic [HIDX_W-1:0] SLOT_LAST = HIDX_W'(HISTORY_BITS - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EVAL  = 6'b000100,
        S_LANE  = 6'b001000,
        S_FINAL = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CLR_W-1:0]                   r_clr_addr;
    logic [msbp_pkg::STRATEGY_W-1:0]    r_strategy;
    logic [THR_W-1:0]                   r_threshold;
    logic                               r_opcode;
    logic [CIDX_W-1:0]                  r_cidx;
    logic [RIDX_W-1:0]                  r_ridx;
    logic                               r_neg;
    logic                               r_taken;
    logic [1:0]                         r_cnt_q;
    logic [ROW_W-1:0]                   r_row_q;
    logic signed [WEIGHT_BITS-1:0]      r_row [ROW_LEN];
    logic [LANE_W-1:0]                  r_lane;
    logic signed [SUM_W-1:0]            r_acc;
    logic [1:0]                         r_hist [HISTORY_BITS];
    logic [HIDX_W-1:0]                  r_slot;
    logic [1:0]                         r_conf;
    logic                               r_res;
    logic                               r_out_valid;
    logic                               r_out_taken;

    logic [1:0]       cnt_mem [COUNTER_ENTRIES];
    logic [ROW_W-1:0] row_mem [PERCEPTRON_ROWS];

    logic                          in_acc;
    logic                          out_free;
    logic                          is_perc;
    logic                          train_skip;
    logic                          simple_pred;
    logic                          cnt_we;
    logic [CIDX_W-1:0]             cnt_waddr;
    logic [1:0]                    cnt_wdata;
    logic [1:0]                    cnt_next;
    logic                          row_we;
    logic [RIDX_W-1:0]             row_waddr;
    logic [ROW_W-1:0]              row_wdata;
    logic [ROW_W-1:0]              row_packed;
    logic                          hist_we;
    msbp_pkg::t_lane_ctl           lane_ctl;
    logic signed [SUM_W-1:0]       lane_sum;
    logic signed [WEIGHT_BITS-1:0] lane_weight;
    logic signed [CMP_W-1:0]       acc_x;
    logic signed [CMP_W-1:0]       thr_x;
    logic [1:0]                    conf_next;

    assign in_acc          = i_valid && o_ready;
    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_predict_taken = r_out_taken;
    assign o_cfg_ready     = 1'b1;
    assign out_free        = !r_out_valid || i_ready;
    assign is_perc         = (r_strategy == msbp_pkg::STRAT_PERCEPTRON);
    assign train_skip      = (r_taken && r_conf == msbp_pkg::CONF_TAKEN) ||
                             (!r_taken && r_conf == msbp_pkg::CONF_NOT);

    // prediction of the strategies that need no arithmetic
    always_comb begin
        unique case (r_strategy)
            msbp_pkg::STRAT_NEVER:    simple_pred = 1'b0;
            msbp_pkg::STRAT_ALWAYS:   simple_pred = 1'b1;
            msbp_pkg::STRAT_BACKWARD: simple_pred = r_neg;
            msbp_pkg::STRAT_COUNTER:  simple_pred = r_cnt_q[1];
            default:                  simple_pred = 1'b0;
        endcase
    end

    // saturating counter step
    always_comb begin
        if (r_taken) begin
            cnt_next = (r_cnt_q == msbp_pkg::CNT_STRONG_T) ? r_cnt_q : r_cnt_q + 2'd1;
        end else begin
            cnt_next = (r_cnt_q == msbp_pkg::CNT_STRONG_NT) ? r_cnt_q : r_cnt_q - 2'd1;
        end
    end

    // memory write muxes, clearing pass or normal writeback
    always_comb begin
        for (int k = 0; k < ROW_LEN; k++) begin
            row_packed[k*WEIGHT_BITS +: WEIGHT_BITS] = r_row[k];
        end
        cnt_we    = (r_state == S_CLEAR) ||
                    (r_state == S_EVAL && r_opcode == msbp_pkg::OP_UPDATE && !is_perc);
        cnt_waddr = (r_state == S_CLEAR) ? r_clr_addr[CIDX_W-1:0] : r_cidx;
        cnt_wdata = (r_state == S_CLEAR) ? msbp_pkg::CNT_WEAK_TAKEN : cnt_next;
        row_we    = (r_state == S_CLEAR) ||
                    (r_state == S_FINAL && r_opcode == msbp_pkg::OP_UPDATE);
        row_waddr = (r_state == S_CLEAR) ? r_clr_addr[RIDX_W-1:0] : r_ridx;
        row_wdata = (r_state == S_CLEAR) ? '0 : row_packed;
        hist_we   = (r_state == S_EVAL && r_opcode == msbp_pkg::OP_UPDATE &&
                     !(is_perc && !train_skip)) ||
                    (r_state == S_FINAL && r_opcode == msbp_pkg::OP_UPDATE);
    end

    // counter table
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (in_acc) begin
            r_cnt_q <= cnt_mem[i_pc[CIDX_W-1:0]];
        end
    end

    // perceptron weight rows, one row per word
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (in_acc) begin
            r_row_q <= row_mem[i_pc[RIDX_W-1:0]];
        end
    end

    // shared lane unit; the last lane is the bias with a fixed +1 input
    always_comb begin
        lane_ctl.train     = (r_opcode == msbp_pkg::OP_UPDATE);
        lane_ctl.dir_taken = r_taken;
        lane_ctl.hist      = (r_lane == LANE_LAST) ? msbp_pkg::HIST_PLUS :
                             r_hist[r_lane[HIDX_W-1:0]];
    end

    msbp_lane_alu #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .SUM_W       (SUM_W)
    ) u_lane_alu (
        .i_acc    (r_acc),
        .i_weight (r_row[r_lane]),
        .i_ctl    (lane_ctl),
        .o_sum    (lane_sum),
        .o_weight (lane_weight)
    );

    // confidence class from the finished dot product
    always_comb begin
        acc_x = {{(CMP_W - SUM_W){r_acc[SUM_W-1]}}, r_acc};
        thr_x = {{(CMP_W - THR_W){1'b0}}, r_threshold};
        if (acc_x > thr_x) begin
            conf_next = msbp_pkg::CONF_TAKEN;
        end else if (acc_x < -thr_x) begin
            conf_next = msbp_pkg::CONF_NOT;
        end else begin
            conf_next = msbp_pkg::CONF_NONE;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == CLR_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_opcode == msbp_pkg::OP_PREDICT) begin
                    n_state = is_perc ? S_LANE : S_EMIT;
                end else begin
                    n_state = (is_perc && !train_skip) ? S_LANE : S_IDLE;
                end
            end
            S_LANE: begin
                if (r_lane == LANE_LAST) n_state = S_FINAL;
            end
            S_FINAL: begin
                n_state = (r_opcode == msbp_pkg::OP_PREDICT) ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_strategy  <= msbp_pkg::STRATEGY_RESET;
            r_threshold <= msbp_pkg::THRESHOLD_RESET;
            r_slot      <= '0;
            r_conf      <= msbp_pkg::CONF_NONE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < HISTORY_BITS; k++) begin
                r_hist[k] <= msbp_pkg::HIST_NONE;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            // register writes
            if (i_cfg_valid) begin
                if (i_cfg_index == msbp_pkg::CFG_STRATEGY) begin
                    r_strategy <= i_cfg_data[msbp_pkg::STRATEGY_W-1:0];
                end else begin
                    r_threshold <= i_cfg_data[THR_W-1:0];
                end
            end
            // output register
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end
            // history ring, round-robin replacement
            if (hist_we) begin
                r_hist[r_slot] <= r_taken ? msbp_pkg::HIST_PLUS : msbp_pkg::HIST_MINUS;
                r_slot         <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
            end
            if (r_state == S_FINAL && r_opcode == msbp_pkg::OP_PREDICT) begin
                r_conf <= conf_next;
            end
        end
    end

    // item payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_opcode <= i_opcode;
            r_cidx   <= i_pc[CIDX_W-1:0];
            r_ridx   <= i_pc[RIDX_W-1:0];
            r_neg    <= i_offset[msbp_pkg::OFFSET_W-1];
            r_taken  <= i_taken;
        end
        if (r_state == S_EMIT && out_free) begin
            r_out_taken <= r_res;
        end
        unique case (r_state)
            S_EVAL: begin
                for (int k = 0; k < ROW_LEN; k++) begin
                    r_row[k] <= r_row_q[k*WEIGHT_BITS +: WEIGHT_BITS];
                end
                r_lane <= '0;
                r_acc  <= '0;
                r_res  <= simple_pred;
            end
            S_LANE: begin
                r_lane <= r_lane + 1'b1;
                if (r_opcode == msbp_pkg::OP_UPDATE) begin
                    r_row[r_lane] <= lane_weight;
                end else begin
                    r_acc <= lane_sum;
                end
            end
            S_FINAL: begin
                r_res <= !r_acc[SUM_W-1];
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

`ifndef SYNTH
    // an accepted item is evaluated in the next cycle
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EVAL))
        else $error("accepted item not evaluated");

    // a result appears only out of the emit step
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside emit");

    // lane walk stays within the row
    a_lane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LANE) |-> (r_lane <= LANE_LAST))
        else $error("lane index past bias");

    // ring slot stays within the history
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_LAST)
        else $error("ring slot out of range");
`endif

endmodule

// File: rtl/core/msbp_lane_alu.sv
module msbp_lane_alu #(
    parameter int WEIGHT_BITS = msbp_pkg::DEF_WEIGHT_BITS,
    parameter int SUM_W       = msbp_pkg::DEF_WEIGHT_BITS + 5
) (
    input  logic signed [SUM_W-1:0]       i_acc,
    input  logic signed [WEIGHT_BITS-1:0] i_weight,
    input  msbp_pkg::t_lane_ctl           i_ctl,
    output logic signed [SUM_W-1:0]       o_sum,
    output logic signed [WEIGHT_BITS-1:0] o_weight
);

    localparam int W_MAX_I = (1 << (WEIGHT_BITS - 1)) - 1;
    localparam logic signed [SUM_W-1:0] W_MAX = SUM_W'(W_MAX_I);
    localparam logic signed [SUM_W-1:0] W_MIN = SUM_W'(-W_MAX_I - 1);
    localparam logic signed [SUM_W-1:0] ONE   = SUM_W'(1);

    logic signed [SUM_W-1:0] w_ext;
    logic signed [SUM_W-1:0] op_a;
    logic signed [SUM_W-1:0] mag;
    logic signed [SUM_W-1:0] op_b;
    logic                    flip;

    // dot product step (acc +- w) or training step (w +- 1) on one adder
    always_comb begin
        w_ext = {{(SUM_W - WEIGHT_BITS){i_weight[WEIGHT_BITS-1]}}, i_weight};
        op_a  = i_ctl.train ? w_ext : i_acc;
        mag   = i_ctl.train ? ONE : w_ext;
        flip  = (i_ctl.hist == msbp_pkg::HIST_MINUS) ^ (i_ctl.train && !i_ctl.dir_taken);
        if (i_ctl.hist == msbp_pkg::HIST_PLUS || i_ctl.hist == msbp_pkg::HIST_MINUS) begin
            op_b = flip ? -mag : mag;
        end else begin
            op_b = '0;
        end
        o_sum = op_a + op_b;
    end

    // clamp to the signed weight range
    always_comb begin
        if (o_sum > W_MAX) begin
            o_weight = W_MAX[WEIGHT_BITS-1:0];
        end else if (o_sum < W_MIN) begin
            o_weight = W_MIN[WEIGHT_BITS-1:0];
        end else begin
            o_weight = o_sum[WEIGHT_BITS-1:0];
        end
    end

endmodule
